/* hdl/blpg_pkg.sv */
`default_nettype none

package blpg_pkg;

	localparam int COORD_BITS_DEF = 6;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic step;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last;
	} dp_status_t;

endpackage

`default_nettype wire

/* hdl/blpg_datapath.sv */
`default_nettype none

module blpg_datapath
	import blpg_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dp_cmd_t               cmd,
	output dp_status_t                 status,
	input  wire logic [COORD_BITS-1:0] x_start,
	input  wire logic [COORD_BITS-1:0] y_start,
	input  wire logic [COORD_BITS-1:0] x_end,
	input  wire logic [COORD_BITS-1:0] y_end,
	output logic      [COORD_BITS-1:0] pixel_x,
	output logic      [COORD_BITS-1:0] pixel_y
);

	localparam int CB = COORD_BITS;
	localparam int DW = COORD_BITS + 3;

	logic [CB-1:0] cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
	logic [CB-1:0] abs_dx_q, abs_dy_q;
	logic          neg_x_q, neg_y_q, y_major_q;
	logic signed [DW-1:0] decision_q;

	// request setup
	logic signed [CB:0]   dx, dy;
	logic [CB-1:0]        adx, ady, ld_major, ld_minor;
	logic                 ld_y_major;
	logic signed [DW-1:0] p_init;

	always_comb begin
		dx = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
		dy = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
		adx = dx[CB] ? CB'(-dx) : dx[CB-1:0];
		ady = dy[CB] ? CB'(-dy) : dy[CB-1:0];
		ld_y_major = ady > adx;
		ld_major = ld_y_major ? ady : adx;
		ld_minor = ld_y_major ? adx : ady;
		p_init = $signed({2'b00, ld_minor, 1'b0}) - $signed({3'b000, ld_major});
	end

	// stepping
	logic [CB-1:0]        major, minor;
	logic                 minor_step;
	logic signed [DW-1:0] p_next;
	logic [CB-1:0]        inc_x, inc_y;
	logic                 step_x, step_y;

	always_comb begin
		major = y_major_q ? abs_dy_q : abs_dx_q;
		minor = y_major_q ? abs_dx_q : abs_dy_q;
		minor_step = !decision_q[DW-1];
		if (minor_step) begin
			p_next = decision_q + $signed({2'b00, minor, 1'b0})
				- $signed({2'b00, major, 1'b0});
		end else begin
			p_next = decision_q + $signed({2'b00, minor, 1'b0});
		end
		step_x = y_major_q ? minor_step : 1'b1;
		step_y = y_major_q ? 1'b1 : minor_step;
		inc_x = {{(CB-1){neg_x_q}}, 1'b1};
		inc_y = {{(CB-1){neg_y_q}}, 1'b1};
		status.last = y_major_q ? (cur_y_q == tgt_y_q) : (cur_x_q == tgt_x_q);
		pixel_x = status.last ? tgt_x_q : cur_x_q;
		pixel_y = status.last ? tgt_y_q : cur_y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			tgt_x_q <= '0;
			tgt_y_q <= '0;
			abs_dx_q <= '0;
			abs_dy_q <= '0;
			neg_x_q <= 1'b0;
			neg_y_q <= 1'b0;
			y_major_q <= 1'b0;
			decision_q <= '0;
		end else if (cmd.load) begin
			cur_x_q <= x_start;
			cur_y_q <= y_start;
			tgt_x_q <= x_end;
			tgt_y_q <= y_end;
			abs_dx_q <= adx;
			abs_dy_q <= ady;
			neg_x_q <= dx[CB];
			neg_y_q <= dy[CB];
			y_major_q <= ld_y_major;
			decision_q <= p_init;
		end else if (cmd.step) begin
			decision_q <= p_next;
			if (step_x) begin
				cur_x_q <= cur_x_q + inc_x;
			end
			if (step_y) begin
				cur_y_q <= cur_y_q + inc_y;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/blpg_ctrl.sv */
`default_nettype none

module blpg_ctrl
	import blpg_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd,
	output logic            busy,
	output logic            pixel_valid,
	output logic            last_pixel
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.load = 1'b0;
		cmd.step = 1'b0;
		busy = 1'b0;
		pixel_valid = 1'b0;
		last_pixel = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				busy = 1'b1;
				pixel_valid = 1'b1;
				cmd.step = 1'b1;
				last_pixel = status.last;
				if (status.last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* hdl/bresenham_line_pixel_generator.sv */
`default_nettype none

// Bresenham line pixel generator. A request (x_start, y_start, x_end, y_end) is
// taken at a rising edge where start is high and busy is low. From that edge on
// busy is high and the block emits one pixel per cycle on pixel_x/pixel_y with
// pixel_valid high, max(|dx|, |dy|) + 1 pixels in all, the end pixel marked by
// last_pixel. Each pixel is on the ports for a single cycle; the receiver cannot
// stall it and must take every transfer. busy drops after the last pixel, and no
// new request is taken before then; the length of a request is set by the
// single-step major-axis walk in the datapath. Ties between |dx| and |dy| step
// along x.

module bresenham_line_pixel_generator
	import blpg_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [COORD_BITS-1:0] x_start,
	input  wire logic [COORD_BITS-1:0] y_start,
	input  wire logic [COORD_BITS-1:0] x_end,
	input  wire logic [COORD_BITS-1:0] y_end,
	output logic                       pixel_valid,
	output logic      [COORD_BITS-1:0] pixel_x,
	output logic      [COORD_BITS-1:0] pixel_y,
	output logic                       last_pixel
);

	dp_cmd_t    cmd;
	dp_status_t status;

	blpg_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.status      (status),
		.cmd         (cmd),
		.busy        (busy),
		.pixel_valid (pixel_valid),
		.last_pixel  (last_pixel)
	);

	blpg_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.x_start (x_start),
		.y_start (y_start),
		.x_end   (x_end),
		.y_end   (y_end),
		.pixel_x (pixel_x),
		.pixel_y (pixel_y)
	);

endmodule

`default_nettype wire
